// ===== sv/hrsp_pkg.sv =====
// Shared types and constants for the HTTP response stream parser.
package hrsp_pkg;

    // Character codes that the parser tests against.
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Saturation limit of the status code accumulator.
    localparam logic [19:0] CODE_MAX = 20'hFFFFF & 20'd65535;

    // Input opcodes.
    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } opcode_t;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_VERSION = 3'd0,
        PH_CODE    = 3'd1,
        PH_REASON  = 3'd2,
        PH_NAME    = 3'd3,
        PH_VSTART  = 3'd4,
        PH_VALUE   = 3'd5,
        PH_BODY    = 3'd6
    } phase_t;

    // Result event kinds.
    typedef enum logic [2:0] {
        EV_STATUS = 3'd0,
        EV_REASON = 3'd1,
        EV_NAME   = 3'd2,
        EV_VALUE  = 3'd3,
        EV_HDONE  = 3'd4,
        EV_HEND   = 3'd5,
        EV_BODY   = 3'd6
    } ev_kind_t;

    // One input beat.
    typedef struct packed {
        logic [0:0] opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  out_byte;
        logic [15:0] status_code;
        logic        last;
    } out_item_t;

    // All results caused by one input byte, as held in the queue.
    typedef struct packed {
        out_item_t first;
        out_item_t second;
        logic      two;
    } res_grp_t;

    // Parser state apart from the pending CR flag.
    typedef struct packed {
        phase_t      phase;
        logic        line_empty;
        logic [15:0] code_acc;
        logic        digits_done;
    } pst_t;

    // Outcome of handling one content byte.
    typedef struct packed {
        pst_t       st;
        logic       emit;
        ev_kind_t   kind;
        logic [7:0] data;
    } cont_t;

    // Queue handshake between front and back.
    typedef struct packed {
        logic valid;
        logic ready;
    } qhs_t;

endpackage

// ===== sv/http_response_stream_parser.sv =====
// Path: an accepted input beat is written into the result group queue, then its
// results into the output register. Throughput: one input beat per cycle while the
// queue is not full (input ready falls only then); one result beat per cycle while
// result_ready is high, so a byte that yields two results holds the output longer, absorbed by the queue.
// Reset (rst_n low, asynchronous) returns the parser to the version phase and
// empties the queue and the output register.
module http_response_stream_parser
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  hrsp_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output hrsp_pkg::out_item_t result
);

    logic               push;
    logic               q_full;
    logic               pop;
    hrsp_pkg::res_grp_t push_grp;
    hrsp_pkg::res_grp_t pop_grp;
    hrsp_pkg::qhs_t     pop_hs;

    hrsp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .q_full     (q_full),
        .push_grp   (push_grp)
    );

    hrsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .full     (q_full),
        .pop_hs   (pop_hs),
        .pop      (pop),
        .pop_grp  (pop_grp)
    );

    hrsp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_hs       (pop_hs),
        .pop          (pop),
        .pop_grp      (pop_grp),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== sv/hrsp_front.sv =====
// Front end: accepts input beats, runs the parser and forms result groups.
module hrsp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  hrsp_pkg::in_item_t item,
    output logic               push,
    input  logic               q_full,
    output hrsp_pkg::res_grp_t push_grp
);

    hrsp_pkg::pst_t st_reg;
    hrsp_pkg::pst_t st_next;
    logic           cr_pending_reg;
    logic           cr_pending_next;
    logic           accept;
    logic           any_res;

    // Handle one content byte in the current phase.
    function automatic hrsp_pkg::cont_t content_step(input hrsp_pkg::pst_t s,
                                                     input logic [7:0] b);
        hrsp_pkg::cont_t r;
        logic [19:0]     v;
        r.st   = s;
        r.emit = 1'b0;
        r.kind = hrsp_pkg::EV_BODY;
        r.data = b;
        v = 20'(s.code_acc) * 20'd10 + 20'(b - hrsp_pkg::CH_ZERO);
        case (s.phase)
            hrsp_pkg::PH_VERSION:
            begin
                if (b == hrsp_pkg::CH_SPACE)
                begin
                    r.st.phase = hrsp_pkg::PH_CODE;
                end
            end
            hrsp_pkg::PH_CODE:
            begin
                if (b == hrsp_pkg::CH_SPACE)
                begin
                    r.st.phase = hrsp_pkg::PH_REASON;
                end
                else if (!s.digits_done && (b inside {[hrsp_pkg::CH_ZERO:hrsp_pkg::CH_NINE]}))
                begin
                    r.st.code_acc = (v > hrsp_pkg::CODE_MAX) ? 16'hFFFF : v[15:0];
                end
                else
                begin
                    r.st.digits_done = 1'b1;
                end
            end
            hrsp_pkg::PH_REASON:
            begin
                r.emit = 1'b1;
                r.kind = hrsp_pkg::EV_REASON;
            end
            hrsp_pkg::PH_NAME:
            begin
                r.st.line_empty = 1'b0;
                if (b == hrsp_pkg::CH_COLON)
                begin
                    r.st.phase = hrsp_pkg::PH_VSTART;
                end
                else
                begin
                    r.emit = 1'b1;
                    r.kind = hrsp_pkg::EV_NAME;
                end
            end
            hrsp_pkg::PH_VSTART:
            begin
                r.st.phase = hrsp_pkg::PH_VALUE;
                if (b != hrsp_pkg::CH_SPACE)
                begin
                    r.emit = 1'b1;
                    r.kind = hrsp_pkg::EV_VALUE;
                end
            end
            hrsp_pkg::PH_VALUE:
            begin
                r.emit = 1'b1;
                r.kind = hrsp_pkg::EV_VALUE;
            end
            default:
            begin
                r.emit = 1'b1;
                r.kind = hrsp_pkg::EV_BODY;
            end
        endcase
        return r;
    endfunction

    // Build a byte-carrying result.
    function automatic hrsp_pkg::out_item_t byte_res(input hrsp_pkg::ev_kind_t k,
                                                     input logic [7:0] b,
                                                     input logic lst);
        hrsp_pkg::out_item_t o;
        o.event_kind  = k;
        o.out_byte    = b;
        o.status_code = 16'd0;
        o.last        = lst;
        return o;
    endfunction

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;
    assign push       = accept && any_res;

    // Parser next state and the results of the current beat.
    always_comb
    begin
        hrsp_pkg::cont_t r1;
        hrsp_pkg::cont_t r2;
        st_next          = st_reg;
        cr_pending_next  = cr_pending_reg;
        any_res          = 1'b0;
        push_grp         = '0;
        r1               = '0;
        r2               = '0;
        if (item.opcode == hrsp_pkg::OP_START)
        begin
            // Start command returns the parser state to reset values.
            st_next.phase       = hrsp_pkg::PH_VERSION;
            st_next.line_empty  = 1'b1;
            st_next.code_acc    = 16'd0;
            st_next.digits_done = 1'b0;
            cr_pending_next     = 1'b0;
        end
        else if (st_reg.phase >= hrsp_pkg::PH_BODY)
        begin
            any_res        = 1'b1;
            push_grp.first = byte_res(hrsp_pkg::EV_BODY, item.rx_byte, 1'b1);
        end
        else if (cr_pending_reg && item.rx_byte == hrsp_pkg::CH_LF)
        begin
            // A CR LF pair ends the line.
            cr_pending_next = 1'b0;
            any_res         = 1'b1;
            push_grp.first  = byte_res(hrsp_pkg::EV_HDONE, 8'd0, 1'b1);
            if (st_reg.phase <= hrsp_pkg::PH_REASON)
            begin
                push_grp.first.event_kind  = hrsp_pkg::EV_STATUS;
                push_grp.first.status_code = st_reg.code_acc;
                st_next.phase              = hrsp_pkg::PH_NAME;
                st_next.line_empty         = 1'b1;
            end
            else if (st_reg.phase == hrsp_pkg::PH_NAME && st_reg.line_empty)
            begin
                push_grp.first.event_kind = hrsp_pkg::EV_HEND;
                st_next.phase             = hrsp_pkg::PH_BODY;
            end
            else
            begin
                st_next.phase      = hrsp_pkg::PH_NAME;
                st_next.line_empty = 1'b1;
            end
        end
        else
        begin
            // A lone CR is released as content before the current byte.
            r1.st = st_reg;
            if (cr_pending_reg)
            begin
                r1 = content_step(st_reg, hrsp_pkg::CH_CR);
            end
            r2.st = r1.st;
            if (item.rx_byte == hrsp_pkg::CH_CR)
            begin
                cr_pending_next = 1'b1;
            end
            else
            begin
                cr_pending_next = 1'b0;
                r2 = content_step(r1.st, item.rx_byte);
            end
            st_next = r2.st;
            any_res = r1.emit || r2.emit;
            if (r1.emit && r2.emit)
            begin
                push_grp.first  = byte_res(r1.kind, r1.data, 1'b0);
                push_grp.second = byte_res(r2.kind, r2.data, 1'b1);
                push_grp.two    = 1'b1;
            end
            else if (r1.emit)
            begin
                push_grp.first = byte_res(r1.kind, r1.data, 1'b1);
            end
            else
            begin
                push_grp.first = byte_res(r2.kind, r2.data, 1'b1);
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase       <= hrsp_pkg::PH_VERSION;
            st_reg.line_empty  <= 1'b1;
            st_reg.code_acc    <= 16'd0;
            st_reg.digits_done <= 1'b0;
            cr_pending_reg     <= 1'b0;
        end
        else if (accept)
        begin
            st_reg         <= st_next;
            cr_pending_reg <= cr_pending_next;
        end
    end

`ifndef SYNTH
    // A two-result group marks only its second result as last.
    a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_grp.two) |-> (!push_grp.first.last && push_grp.second.last))
        else $error("two-result group has wrong last flags");
`endif

endmodule

// ===== sv/hrsp_queue.sv =====
// Result group queue between the parser front end and the output back end.
module hrsp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hrsp_pkg::res_grp_t push_grp,
    output logic               full,
    output hrsp_pkg::qhs_t     pop_hs,
    input  logic               pop,
    output hrsp_pkg::res_grp_t pop_grp
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrsp_pkg::res_grp_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;

    assign full         = (count_reg == CNT_W'(DEPTH));
    assign pop_hs.valid = (count_reg != '0);
    assign pop_hs.ready = pop;
    assign do_pop       = pop && pop_hs.valid;
    assign pop_grp      = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_grp;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

// ===== sv/hrsp_back.sv =====
// Back end: takes result groups from the queue and delivers one result per beat.
module hrsp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  hrsp_pkg::qhs_t      pop_hs,
    output logic                pop,
    input  hrsp_pkg::res_grp_t  pop_grp,
    output logic                result_valid,
    input  logic                result_ready,
    output hrsp_pkg::out_item_t result
);

    hrsp_pkg::out_item_t result_reg;
    hrsp_pkg::out_item_t second_reg;
    logic                valid_reg;
    logic                has_second_reg;
    logic                advance;

    assign advance      = !valid_reg || result_ready;
    assign pop          = advance && !has_second_reg && pop_hs.valid;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    // Control: the held second result goes before the next group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            has_second_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (has_second_reg)
            begin
                valid_reg      <= 1'b1;
                has_second_reg <= 1'b0;
            end
            else if (pop_hs.valid)
            begin
                valid_reg      <= 1'b1;
                has_second_reg <= pop_grp.two;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (has_second_reg)
            begin
                result_reg <= second_reg;
            end
            else if (pop_hs.valid)
            begin
                result_reg <= pop_grp.first;
                second_reg <= pop_grp.second;
            end
        end
    end

`ifndef SYNTH
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        has_second_reg |-> (valid_reg && !result_reg.last))
        else $error("held second result without a pending first");
`endif

endmodule

// ===== verif/http_response_stream_parser_tb.sv =====
// Self-checking testbench for the HTTP response stream parser.
module http_response_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;

    // One row of the directed stimulus table.
    typedef struct {
        hrsp_pkg::in_item_t  beat;
        logic                pinned;
        hrsp_pkg::out_item_t want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    hrsp_pkg::in_item_t  item;
    logic                result_valid;
    logic                result_ready;
    hrsp_pkg::out_item_t result;

    // Model of the parser state.
    hrsp_pkg::phase_t hdr_phase;
    logic             cr_held;
    logic             line_blank;
    logic [15:0]      code_sum;
    logic             code_closed;

    hrsp_pkg::out_item_t beat_events[$];
    hrsp_pkg::out_item_t expected_events[$];
    int        error_count = 0;
    int        items_sent = 0;
    int        cycle_count = 0;
    logic      no_idle = 1'b0;
    logic      hold_off = 1'b0;
    stim_row_t directed_rows[29];

    http_response_stream_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Free-running clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic hrsp_pkg::out_item_t make_event(hrsp_pkg::ev_kind_t k, logic [7:0] d,
                                                       logic [15:0] c);
        hrsp_pkg::out_item_t e;
        e.event_kind  = k;
        e.out_byte    = d;
        e.status_code = c;
        e.last        = 1'b0;
        return e;
    endfunction

    function automatic hrsp_pkg::in_item_t data_beat(logic [7:0] c);
        hrsp_pkg::in_item_t b;
        b.opcode  = hrsp_pkg::OP_DATA;
        b.rx_byte = c;
        return b;
    endfunction

    function automatic stim_row_t data_row(logic [7:0] c);
        stim_row_t r;
        r.beat   = data_beat(c);
        r.pinned = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    // A row whose single result is written out by hand.
    function automatic stim_row_t pin_row(logic [7:0] c, hrsp_pkg::ev_kind_t k,
                                          logic [7:0] d, logic [15:0] code);
        stim_row_t r;
        r.beat      = data_beat(c);
        r.pinned    = 1'b1;
        r.want      = make_event(k, d, code);
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 5) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic clear_parser();
        hdr_phase   = hrsp_pkg::PH_VERSION;
        cr_held     = 1'b0;
        line_blank  = 1'b1;
        code_sum    = '0;
        code_closed = 1'b0;
    endtask

    // Handles one content byte in the current phase; returns 1 when it yields an event.
    function automatic logic take_content(input logic [7:0] c,
                                          output hrsp_pkg::ev_kind_t k);
        int unsigned sum;
        k = hrsp_pkg::EV_BODY;
        case (hdr_phase)
            hrsp_pkg::PH_VERSION:
            begin
                if (c == hrsp_pkg::CH_SPACE)
                    hdr_phase = hrsp_pkg::PH_CODE;
                return 1'b0;
            end
            hrsp_pkg::PH_CODE:
            begin
                if (c == hrsp_pkg::CH_SPACE)
                    hdr_phase = hrsp_pkg::PH_REASON;
                else if (!code_closed && c >= hrsp_pkg::CH_ZERO && c <= hrsp_pkg::CH_NINE)
                begin
                    sum = code_sum * 10 + (c - hrsp_pkg::CH_ZERO);
                    code_sum = (sum > 65535) ? 16'hFFFF : sum[15:0];
                end
                else
                    code_closed = 1'b1;
                return 1'b0;
            end
            hrsp_pkg::PH_REASON:
            begin
                k = hrsp_pkg::EV_REASON;
                return 1'b1;
            end
            hrsp_pkg::PH_NAME:
            begin
                line_blank = 1'b0;
                if (c == hrsp_pkg::CH_COLON)
                begin
                    hdr_phase = hrsp_pkg::PH_VSTART;
                    return 1'b0;
                end
                k = hrsp_pkg::EV_NAME;
                return 1'b1;
            end
            hrsp_pkg::PH_VSTART:
            begin
                hdr_phase = hrsp_pkg::PH_VALUE;
                k = hrsp_pkg::EV_VALUE;
                return c != hrsp_pkg::CH_SPACE;
            end
            hrsp_pkg::PH_VALUE:
            begin
                k = hrsp_pkg::EV_VALUE;
                return 1'b1;
            end
            default:
                return 1'b1;
        endcase
    endfunction

    // Closes the current line on CR LF and returns the event it reports.
    function automatic hrsp_pkg::ev_kind_t finish_line();
        if (hdr_phase <= hrsp_pkg::PH_REASON)
        begin
            hdr_phase  = hrsp_pkg::PH_NAME;
            line_blank = 1'b1;
            return hrsp_pkg::EV_STATUS;
        end
        if (hdr_phase == hrsp_pkg::PH_NAME && line_blank)
        begin
            hdr_phase = hrsp_pkg::PH_BODY;
            return hrsp_pkg::EV_HEND;
        end
        hdr_phase  = hrsp_pkg::PH_NAME;
        line_blank = 1'b1;
        return hrsp_pkg::EV_HDONE;
    endfunction

    // Works out the events that one accepted input beat produces.
    task automatic parse_beat(input hrsp_pkg::in_item_t b);
        hrsp_pkg::ev_kind_t k;
        beat_events.delete();
        if (b.opcode == hrsp_pkg::OP_START)
        begin
            clear_parser();
            return;
        end
        if (hdr_phase >= hrsp_pkg::PH_BODY)
            beat_events.push_back(make_event(hrsp_pkg::EV_BODY, b.rx_byte, 16'h0000));
        else if (cr_held && b.rx_byte == hrsp_pkg::CH_LF)
        begin
            cr_held = 1'b0;
            k = finish_line();
            beat_events.push_back(make_event(k, 8'h00,
                                             (k == hrsp_pkg::EV_STATUS) ? code_sum
                                                                        : 16'h0000));
        end
        else
        begin
            // A CR that was not followed by LF counts as content.
            if (cr_held)
            begin
                cr_held = 1'b0;
                if (take_content(hrsp_pkg::CH_CR, k))
                    beat_events.push_back(make_event(k, hrsp_pkg::CH_CR, 16'h0000));
            end
            if (b.rx_byte == hrsp_pkg::CH_CR)
                cr_held = 1'b1;
            else if (take_content(b.rx_byte, k))
                beat_events.push_back(make_event(k, b.rx_byte, 16'h0000));
        end
        if (beat_events.size() > 0)
            beat_events[beat_events.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Offers one input beat, waits for it to be taken and records what it should yield.
    task automatic send_beat(input hrsp_pkg::in_item_t b, input logic pinned,
                             input hrsp_pkg::out_item_t want);
        logic steady;
        steady = (items_sent >= 500 && items_sent < 700);
        no_idle <= steady;
        while (!steady && $urandom_range(0, 99) < 14)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= b;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        parse_beat(b);
        if (pinned)
            expected_events.push_back(want);
        else
            foreach (beat_events[i])
                expected_events.push_back(beat_events[i]);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        send_beat(data_beat(c), 1'b0, '0);
    endtask

    task automatic send_line_end();
        send_byte(hrsp_pkg::CH_CR);
        send_byte(hrsp_pkg::CH_LF);
    endtask

    // One random response: mostly well formed, with random content and a few breaks.
    task automatic send_response();
        hrsp_pkg::in_item_t b;
        int n;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                b.opcode  = ($urandom_range(0, 3) == 0) ? hrsp_pkg::OP_START
                                                        : hrsp_pkg::OP_DATA;
                b.rx_byte = 8'($urandom_range(0, 255));
                send_beat(b, 1'b0, '0);
            end
            return;
        end
        b.opcode  = hrsp_pkg::OP_START;
        b.rx_byte = 8'($urandom_range(0, 255));
        send_beat(b, 1'b0, '0);

        // Status line: version, code, reason.
        repeat ($urandom_range(0, 8))
            send_byte(8'($urandom_range(33, 126)));
        if ($urandom_range(0, 7) != 0)
        begin
            send_byte(hrsp_pkg::CH_SPACE);
            repeat ($urandom_range(0, 6))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(text_char());
                else
                    send_byte(8'($urandom_range(hrsp_pkg::CH_ZERO, hrsp_pkg::CH_NINE)));
            end
            if ($urandom_range(0, 5) != 0)
            begin
                send_byte(hrsp_pkg::CH_SPACE);
                repeat ($urandom_range(0, 6))
                    send_byte(text_char());
            end
        end
        send_line_end();

        // Header lines.
        repeat ($urandom_range(0, 4))
        begin
            repeat ($urandom_range(1, 6))
                send_byte(text_char());
            if ($urandom_range(0, 7) != 0)
            begin
                send_byte(hrsp_pkg::CH_COLON);
                if ($urandom_range(0, 1) == 0)
                    send_byte(hrsp_pkg::CH_SPACE);
                repeat ($urandom_range(0, 6))
                    send_byte(text_char());
            end
            send_line_end();
        end

        // Blank line, then body bytes of any value.
        if ($urandom_range(0, 9) != 0)
            send_line_end();
        repeat ($urandom_range(0, 8))
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Result side: check each beat taken, then pick the next ready level.
    always @(posedge clk)
    begin
        hrsp_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_events.size() == 0)
                report_mismatch("result with nothing expected", 32'(result), 32'h0);
            else
            begin
                want = expected_events.pop_front();
                if (result.event_kind != want.event_kind)
                    report_mismatch("event_kind", 32'(result.event_kind), 32'(want.event_kind));
                if (result.out_byte != want.out_byte)
                    report_mismatch("out_byte", 32'(result.out_byte), 32'(want.out_byte));
                if (result.status_code != want.status_code)
                    report_mismatch("status_code", 32'(result.status_code),
                                    32'(want.status_code));
                if (result.last != want.last)
                    report_mismatch("last", 32'(result.last), 32'(want.last));
            end
        end
        result_ready <= !hold_off && (no_idle || $urandom_range(0, 99) >= 14);
    end

    // Long receiver hold-off so the result queue fills and input stalls.
    initial
    begin
        int held;
        held = 0;
        while (items_sent < 300)
            @(posedge clk);
        hold_off <= 1'b1;
        while (held < HOLD_CYCLES)
        begin
            @(posedge clk);
            held++;
        end
        hold_off <= 1'b0;
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[http_response_stream_parser] ERROR");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        directed_rows = '{
            data_row(8'h48),                                 // version text is skipped
            data_row(hrsp_pkg::CH_SPACE),
            data_row(hrsp_pkg::CH_NINE), data_row(hrsp_pkg::CH_NINE),
            data_row(hrsp_pkg::CH_NINE), data_row(hrsp_pkg::CH_NINE),
            data_row(hrsp_pkg::CH_NINE),                     // 99999 saturates
            data_row(8'h78),                                 // non-digit ends the code
            data_row(8'h37),                                 // later digit ignored
            data_row(hrsp_pkg::CH_SPACE),
            pin_row(8'hFF, hrsp_pkg::EV_REASON, 8'hFF, 16'h0000),
            data_row(hrsp_pkg::CH_CR), data_row(8'h41),      // lone CR inside reason
            data_row(hrsp_pkg::CH_CR),
            pin_row(hrsp_pkg::CH_LF, hrsp_pkg::EV_STATUS, 8'h00, 16'hFFFF),
            data_row(8'h4E), data_row(hrsp_pkg::CH_COLON), data_row(hrsp_pkg::CH_SPACE),
            data_row(hrsp_pkg::CH_LF),                       // lone LF is value content
            data_row(hrsp_pkg::CH_CR),
            pin_row(hrsp_pkg::CH_LF, hrsp_pkg::EV_HDONE, 8'h00, 16'h0000),
            pin_row(8'h00, hrsp_pkg::EV_NAME, 8'h00, 16'h0000), // header with no colon
            data_row(hrsp_pkg::CH_CR),
            pin_row(hrsp_pkg::CH_LF, hrsp_pkg::EV_HDONE, 8'h00, 16'h0000),
            data_row(hrsp_pkg::CH_CR),
            pin_row(hrsp_pkg::CH_LF, hrsp_pkg::EV_HEND, 8'h00, 16'h0000),
            pin_row(8'hFF, hrsp_pkg::EV_BODY, 8'hFF, 16'h0000),
            data_row(hrsp_pkg::CH_CR),                       // CR in body passes through
            '{beat: '{opcode: hrsp_pkg::OP_START, rx_byte: 8'h00}, pinned: 1'b0, want: '0}
        };

        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        clear_parser();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].want);

        while (items_sent < ITEM_TARGET)
            send_response();
        item_valid <= 1'b0;

        // Drain, then allow for any late beats.
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("[http_response_stream_parser] OK");
        else
            $display("[http_response_stream_parser] ERROR");
        $finish;
    end

endmodule
